// ===== sv/obdrd_pkg.sv =====
`default_nettype none
package obdrd_pkg;

   localparam int MAX_CODES = 3;
   localparam int NUM_PIDS  = 5;
   localparam int NUM_SLOTS = 3;

   localparam logic [7:0] SVC_LIVE    = 8'h41;
   localparam logic [7:0] SVC_CODES   = 8'h43;
   localparam logic [7:0] SVC_CLEARED = 8'h44;

   localparam logic [2:0] CSR_RPM_PID      = 3'd0;
   localparam logic [2:0] CSR_SPEED_PID    = 3'd1;
   localparam logic [2:0] CSR_FUEL_PID     = 3'd2;
   localparam logic [2:0] CSR_AIRFLOW_PID  = 3'd3;
   localparam logic [2:0] CSR_THROTTLE_PID = 3'd4;

   // ceil(2^24 / 100); exact floor division for any 16-bit dividend
   localparam logic [17:0] DIV100_RECIP = 18'd167773;
   localparam int          DIV100_SHIFT = 24;
   localparam logic [6:0]  THROTTLE_MUL = 7'd100;

   typedef enum logic [1:0] {
      KIND_LIVE    = 2'd0,
      KIND_CODE    = 2'd1,
      KIND_NONE    = 2'd2,
      KIND_CLEARED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      QTY_RPM      = 3'd0,
      QTY_SPEED    = 3'd1,
      QTY_FUEL     = 3'd2,
      QTY_AIRFLOW  = 3'd3,
      QTY_THROTTLE = 3'd4
   } quantity_type;

   // frame byte 0 is the length, byte 1 the service
   typedef logic [7:0][7:0] frame_type;

   typedef logic [NUM_PIDS-1:0][7:0] pid_set_type;

   localparam pid_set_type PID_RESET = {8'd17, 8'd16, 8'd10, 8'd13, 8'd12};

   typedef struct packed {
      kind_type     kind;
      quantity_type quantity;
      logic [15:0]  scaled_value;
      logic [1:0]   code_index;
      logic [1:0]   code_system;
      logic [1:0]   digit_one;
      logic [3:0]   digit_two;
      logic [3:0]   digit_three;
      logic [3:0]   digit_four;
      logic         last;
   } result_type;

   typedef struct packed {
      logic [1:0]                      count;
      result_type [NUM_SLOTS-1:0]      items;
   } batch_type;

endpackage
`default_nettype wire

// ===== sv/obd_response_decoder_unit.sv =====
`default_nettype none
// Diagnostic response frame decoder.
// Request channel (req_*): one 8-byte response frame per request, taken at
// a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): decoded results, taken with rsp_valid high and
// rsp_stall low. A frame gives 0 to 3 results; rsp_last marks its final one.
// Registers (csr_*): five PID numbers, written at any edge with csr_write
// high; indexes above the list are ignored.
// A frame passes the input register, then the result register, before its
// first result is offered.
// Throughput: one result per cycle while the receiver does not stall; a frame
// holds the result register until its last result is taken, so single-result
// frames flow at one per cycle. The result register drains one entry a cycle
// while unstalled and sets this figure.
// A frame with no result is dropped at the result register.
// Reset (synchronous) empties both registers and restores the default PIDs.
// While the receiver stalls, the current result holds and the input
// register still takes one more request before req_stall rises.
module obd_response_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_frame_len,
   input  wire logic [7:0]  req_response_code,
   input  wire logic [7:0]  req_payload_2,
   input  wire logic [7:0]  req_payload_3,
   input  wire logic [7:0]  req_payload_4,
   input  wire logic [7:0]  req_payload_5,
   input  wire logic [7:0]  req_payload_6,
   input  wire logic [7:0]  req_payload_7,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_quantity,
   output logic [15:0]      rsp_scaled_value,
   output logic [1:0]       rsp_code_index,
   output logic [1:0]       rsp_code_system,
   output logic [1:0]       rsp_digit_one,
   output logic [3:0]       rsp_digit_two,
   output logic [3:0]       rsp_digit_three,
   output logic [3:0]       rsp_digit_four,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import obdrd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   frame_type   frame_ff, frame_in;
   pid_set_type pids;
   batch_type   batch;
   result_type  rsp;
   logic        load;
   logic        accept;

   assign req_stall = in_valid_ff && !load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      frame_in    = frame_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         frame_in    = {req_payload_7, req_payload_6, req_payload_5, req_payload_4,
                        req_payload_3, req_payload_2, req_response_code, req_frame_len};
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   obdrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pids      (pids)
   );

   obdrd_decode u_decode (
      .frame (frame_ff),
      .pids  (pids),
      .batch (batch)
   );

   obdrd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .batch     (batch),
      .load      (load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_quantity     = rsp.quantity;
   assign rsp_scaled_value = rsp.scaled_value;
   assign rsp_code_index   = rsp.code_index;
   assign rsp_code_system  = rsp.code_system;
   assign rsp_digit_one    = rsp.digit_one;
   assign rsp_digit_two    = rsp.digit_two;
   assign rsp_digit_three  = rsp.digit_three;
   assign rsp_digit_four   = rsp.digit_four;
   assign rsp_last         = rsp.last;

endmodule
`default_nettype wire

// ===== sv/obdrd_csr.sv =====
`default_nettype none
module obdrd_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [7:0]           csr_data,
   output obdrd_pkg::pid_set_type    pids
);
   import obdrd_pkg::*;

   pid_set_type pid_ff, pid_in;

   always_comb begin
      pid_in = pid_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RPM_PID:      pid_in[QTY_RPM]      = csr_data;
            CSR_SPEED_PID:    pid_in[QTY_SPEED]    = csr_data;
            CSR_FUEL_PID:     pid_in[QTY_FUEL]     = csr_data;
            CSR_AIRFLOW_PID:  pid_in[QTY_AIRFLOW]  = csr_data;
            CSR_THROTTLE_PID: pid_in[QTY_THROTTLE] = csr_data;
            default:          pid_in = pid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= PID_RESET;
      end else begin
         pid_ff <= pid_in;
      end
   end

   assign pids = pid_ff;

endmodule
`default_nettype wire

// ===== sv/obdrd_decode.sv =====
`default_nettype none
module obdrd_decode (
   input  wire obdrd_pkg::frame_type   frame,
   input  wire obdrd_pkg::pid_set_type pids,
   output obdrd_pkg::batch_type        batch
);
   import obdrd_pkg::*;

   logic [7:0]   len;
   logic [7:0]   pid;
   logic [15:0]  raw;
   logic [33:0]  air_prod;
   logic [22:0]  thr_prod;
   logic [15:0]  value;
   logic         hit;
   quantity_type qty;
   logic [7:0]   len_m1;
   logic [6:0]   half;
   logic [1:0]   ncodes;

   assign len = frame[0];
   assign pid = (len >= 8'd2) ? frame[2] : 8'd0;

   // only the last two bytes shifted in survive
   always_comb begin
      if (len >= 8'd7) begin
         raw = {frame[6], frame[7]};
      end else begin
         case (len[2:0])
            3'd3:    raw = {8'd0, frame[3]};
            3'd4:    raw = {frame[3], frame[4]};
            3'd5:    raw = {frame[4], frame[5]};
            3'd6:    raw = {frame[5], frame[6]};
            default: raw = 16'd0;
         endcase
      end
   end

   // first match wins
   always_comb begin
      hit = 1'b0;
      qty = QTY_RPM;
      for (int q = NUM_PIDS - 1; q >= 0; q--) begin
         if (pids[q] == pid) begin
            hit = 1'b1;
            qty = quantity_type'(3'(q));
         end
      end
   end

   assign air_prod = {18'd0, raw} * {16'd0, DIV100_RECIP};
   assign thr_prod = {7'd0, raw} * {16'd0, THROTTLE_MUL};

   always_comb begin
      case (qty)
         QTY_RPM:      value = {2'b00, raw[15:2]};
         QTY_SPEED:    value = raw;
         QTY_FUEL:     value = raw + {raw[14:0], 1'b0};
         QTY_AIRFLOW:  value = {6'd0, air_prod[DIV100_SHIFT +: 10]};
         QTY_THROTTLE: value = {1'b0, thr_prod[22:8]};
         default:      value = 16'd0;
      endcase
   end

   assign len_m1 = len - 8'd1;
   assign half   = len_m1[7:1];
   always_comb begin
      if (len == 8'd0) begin
         ncodes = 2'd0;
      end else if (half >= 7'(MAX_CODES)) begin
         ncodes = 2'(MAX_CODES);
      end else begin
         ncodes = half[1:0];
      end
   end

   always_comb begin
      batch = '0;
      unique case (frame[1])
         SVC_LIVE: begin
            if (hit) begin
               batch.count                 = 2'd1;
               batch.items[0].kind         = KIND_LIVE;
               batch.items[0].quantity     = qty;
               batch.items[0].scaled_value = value;
               batch.items[0].last         = 1'b1;
            end
         end
         SVC_CODES: begin
            if (ncodes == 2'd0) begin
               batch.count          = 2'd1;
               batch.items[0].kind  = KIND_NONE;
               batch.items[0].last  = 1'b1;
            end else begin
               batch.count = ncodes;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (2'(i) < ncodes) begin
                     batch.items[i].kind        = KIND_CODE;
                     batch.items[i].code_index  = 2'(i);
                     batch.items[i].code_system = frame[2 + 2 * i][7:6];
                     batch.items[i].digit_one   = frame[2 + 2 * i][5:4];
                     batch.items[i].digit_two   = frame[2 + 2 * i][3:0];
                     batch.items[i].digit_three = frame[3 + 2 * i][7:4];
                     batch.items[i].digit_four  = frame[3 + 2 * i][3:0];
                     batch.items[i].last        = (2'(i + 1) == ncodes);
                  end
               end
            end
         end
         SVC_CLEARED: begin
            batch.count         = 2'd1;
            batch.items[0].kind = KIND_CLEARED;
            batch.items[0].last = 1'b1;
         end
         default: batch = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/obdrd_emit.sv =====
`default_nettype none
module obdrd_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire obdrd_pkg::batch_type batch,
   output logic                      load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output obdrd_pkg::result_type     rsp
);
   import obdrd_pkg::*;

   logic       bat_valid_ff, bat_valid_in;
   logic [1:0] ptr_ff, ptr_in;
   batch_type  batch_ff, batch_in;
   result_type cur;
   logic       take;

   assign cur  = batch_ff.items[ptr_ff];
   assign take = bat_valid_ff && !rsp_stall;
   assign load = in_valid && (!bat_valid_ff || (take && cur.last));

   always_comb begin
      bat_valid_in = bat_valid_ff;
      ptr_in       = ptr_ff;
      batch_in     = batch_ff;
      if (load) begin
         bat_valid_in = (batch.count != 2'd0);
         ptr_in       = 2'd0;
         batch_in     = batch;
      end else if (take) begin
         if (cur.last) begin
            bat_valid_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bat_valid_ff <= 1'b0;
         ptr_ff       <= 2'd0;
      end else begin
         bat_valid_ff <= bat_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
   end

   assign rsp_valid = bat_valid_ff;
   assign rsp       = cur;

endmodule
`default_nettype wire

// ===== test/obd_response_decoder_unit_tb.sv =====
`default_nettype none
module obd_response_decoder_unit_tb;
   import obdrd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_frame_len = '0;
   logic [7:0]  req_response_code = '0;
   logic [7:0]  req_payload_2 = '0;
   logic [7:0]  req_payload_3 = '0;
   logic [7:0]  req_payload_4 = '0;
   logic [7:0]  req_payload_5 = '0;
   logic [7:0]  req_payload_6 = '0;
   logic [7:0]  req_payload_7 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_quantity;
   logic [15:0] rsp_scaled_value;
   logic [1:0]  rsp_code_index;
   logic [1:0]  rsp_code_system;
   logic [1:0]  rsp_digit_one;
   logic [3:0]  rsp_digit_two;
   logic [3:0]  rsp_digit_three;
   logic [3:0]  rsp_digit_four;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   frame_type  pending_frames[$];
   result_type expected_results[$];
   logic [7:0] pid_table [NUM_PIDS];
   int         send_idle_pct = 12;
   int         recv_idle_pct = 51;
   int         error_count = 0;

   obd_response_decoder_unit i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   // expected results of one accepted request
   function automatic void decode_frame(input frame_type f);
      result_type  r;
      logic [7:0]  len, top, pid, hi, lo;
      logic [15:0] raw;
      logic [31:0] wide;
      int          i, q, n;
      len = f[0];
      r = '0;
      r.last = 1'b1;
      case (f[1])
         SVC_LIVE: begin
            top = (len > 8'd7) ? 8'd7 : len;
            pid = (len >= 8'd2) ? f[2] : 8'd0;
            raw = '0;
            for (i = 3; i <= int'(top); i++) raw = {raw[7:0], f[i]};
            q = NUM_PIDS;
            for (i = NUM_PIDS - 1; i >= 0; i--) if (pid_table[i] == pid) q = i;
            if (q < NUM_PIDS) begin
               r.kind = KIND_LIVE;
               r.quantity = quantity_type'(q);
               case (r.quantity)
                  QTY_RPM:      r.scaled_value = raw >> 2;
                  QTY_SPEED:    r.scaled_value = raw;
                  QTY_FUEL: begin
                     wide = 32'(raw) * 3;
                     r.scaled_value = wide[15:0];
                  end
                  QTY_AIRFLOW:  r.scaled_value = raw / 16'd100;
                  default: begin
                     wide = (32'(raw) * 100) >> 8;
                     r.scaled_value = wide[15:0];
                  end
               endcase
               expected_results.push_back(r);
            end
         end
         SVC_CODES: begin
            n = (len == 8'd0) ? 0 : (int'(len) - 1) / 2;
            if (n > MAX_CODES) n = MAX_CODES;
            if (n > 3) n = 3;
            if (n == 0) begin
               r.kind = KIND_NONE;
               expected_results.push_back(r);
            end
            for (i = 0; i < n; i++) begin
               hi = f[2 + 2 * i];
               lo = f[3 + 2 * i];
               r = '0;
               r.kind = KIND_CODE;
               r.code_index = 2'(i);
               r.code_system = hi[7:6];
               r.digit_one = hi[5:4];
               r.digit_two = hi[3:0];
               r.digit_three = lo[7:4];
               r.digit_four = lo[3:0];
               r.last = (i == n - 1);
               expected_results.push_back(r);
            end
         end
         SVC_CLEARED: begin
            r.kind = KIND_CLEARED;
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic frame_type make_frame(input logic [7:0] len, svc, p2, p3, p4, p5,
                                            p6, p7);
      return {p7, p6, p5, p4, p3, p2, svc, len};
   endfunction

   // mostly well-formed frames of the three services, some noise
   function automatic frame_type random_frame();
      frame_type f;
      int        pick, r;
      f = frame_type'({$urandom, $urandom});
      pick = $urandom_range(99);
      r = $urandom_range(9);
      if (pick < 45) begin
         f[1] = SVC_LIVE;
         if (r < 8) f[0] = 8'($urandom_range(7, 2));
         else if (r == 8) f[0] = 8'($urandom_range(1));
         if ($urandom_range(4) != 0) f[2] = pid_table[$urandom_range(NUM_PIDS - 1)];
      end else if (pick < 75) begin
         f[1] = SVC_CODES;
         if (r < 9) f[0] = 8'($urandom_range(8));
      end else if (pick < 85) begin
         f[1] = SVC_CLEARED;
      end
      return f;
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index < NUM_PIDS) pid_table[index] = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      do @(negedge clock); while (pending_frames.size() != 0 || req_valid);
      while (expected_results.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never came",
                                   expected_results.size()));
         expected_results.delete();
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) pending_frames.push_back(random_frame());
   endtask

   // request driver
   always @(posedge clock) begin
      frame_type next_frame;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_frame({req_payload_7, req_payload_6, req_payload_5, req_payload_4,
                          req_payload_3, req_payload_2, req_response_code, req_frame_len});
         end
         if (!req_valid || !req_stall) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_frame = pending_frames.pop_front();
               req_frame_len <= next_frame[0];
               req_response_code <= next_frame[1];
               req_payload_2 <= next_frame[2];
               req_payload_3 <= next_frame[3];
               req_payload_4 <= next_frame[4];
               req_payload_5 <= next_frame[5];
               req_payload_6 <= next_frame[6];
               req_payload_7 <= next_frame[7];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("kind", rsp_kind, want.kind);
               check_field("quantity", rsp_quantity, want.quantity);
               check_field("scaled_value", rsp_scaled_value, want.scaled_value);
               check_field("code_index", rsp_code_index, want.code_index);
               check_field("code_system", rsp_code_system, want.code_system);
               check_field("digit_one", rsp_digit_one, want.digit_one);
               check_field("digit_two", rsp_digit_two, want.digit_two);
               check_field("digit_three", rsp_digit_three, want.digit_three);
               check_field("digit_four", rsp_digit_four, want.digit_four);
               check_field("last", rsp_last, want.last);
            end
         end
      end
   end

   initial begin
      #400000;
      $display("obd_response_decoder_unit_tb NOT OK");
      $finish;
   end

   initial begin
      int idx;
      for (idx = 0; idx < NUM_PIDS; idx++) pid_table[idx] = PID_RESET[idx];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default PIDs
      pending_frames.push_back(make_frame(4, SVC_LIVE, PID_RESET[0], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(3, SVC_LIVE, PID_RESET[1], 8'hFF, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(4, SVC_LIVE, PID_RESET[2], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(4, SVC_LIVE, PID_RESET[3], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(4, SVC_LIVE, PID_RESET[4], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(8'hFF, SVC_LIVE, PID_RESET[0], 8'h11, 8'h22, 8'h33,
                                          8'h44, 8'h55));
      pending_frames.push_back(make_frame(2, SVC_LIVE, PID_RESET[1], 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 8'hFF));
      pending_frames.push_back(make_frame(1, SVC_LIVE, PID_RESET[0], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(4, SVC_LIVE, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(7, SVC_LIVE, PID_RESET[4], 0, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(0, SVC_CODES, 8'hFF, 8'hFF, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(2, SVC_CODES, 8'hFF, 8'hFF, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(3, SVC_CODES, 8'hFF, 8'hFF, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(5, SVC_CODES, 0, 0, 8'hC3, 8'h5A, 8'hFF, 8'hFF));
      pending_frames.push_back(make_frame(7, SVC_CODES, 8'hA5, 8'h5A, 8'h12, 8'h34, 8'hFF, 0));
      pending_frames.push_back(make_frame(8'hFF, SVC_CODES, 8'h3C, 8'hC3, 8'h80, 8'h01,
                                          8'h7E, 8'hE7));
      pending_frames.push_back(make_frame(0, SVC_CLEARED, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 8'hFF));
      pending_frames.push_back(make_frame(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF, 8'hFF));
      pending_frames.push_back(make_frame(4, 8'hFF, PID_RESET[0], 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(1, SVC_CODES - 8'd1, 0, 0, 0, 0, 0, 0));
      queue_random(100);
      drain_results();

      // extreme and duplicate PIDs
      send_idle_pct = 51;
      recv_idle_pct = 12;
      write_csr(CSR_RPM_PID, 8'h00);
      write_csr(CSR_SPEED_PID, 8'hFF);
      write_csr(CSR_FUEL_PID, 8'h00);
      write_csr(CSR_AIRFLOW_PID, 8'hFF);
      write_csr(CSR_THROTTLE_PID, 8'h80);
      for (idx = NUM_PIDS; idx < 8; idx++) write_csr(3'(idx), 8'($urandom));
      pending_frames.push_back(make_frame(0, SVC_LIVE, 8'h55, 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(1, SVC_LIVE, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0));
      pending_frames.push_back(make_frame(3, SVC_LIVE, 8'hFF, 8'hFF, 0, 0, 0, 0));
      pending_frames.push_back(make_frame(3, SVC_LIVE, 8'h80, 8'h80, 0, 0, 0, 0));
      queue_random(100);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_RPM_PID, 8'($urandom));
      write_csr(CSR_SPEED_PID, 8'($urandom));
      write_csr(CSR_FUEL_PID, 8'($urandom));
      write_csr(CSR_AIRFLOW_PID, 8'($urandom));
      write_csr(CSR_THROTTLE_PID, 8'($urandom));
      queue_random(100);
      drain_results();

      if (error_count == 0) begin
         $display("obd_response_decoder_unit_tb OK");
      end else begin
         $display("obd_response_decoder_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/obdrd_pkg.sv
sv/obdrd_csr.sv
sv/obdrd_decode.sv
sv/obdrd_emit.sv
sv/obd_response_decoder_unit.sv
test/obd_response_decoder_unit_tb.sv
